[rtl/cls_pkg.sv]
// Package for the conflict layer scheduler.
// Holds sizing constants and the transaction and table entry types.
// No dependencies.
package cls_pkg;

    localparam int MAX_SYSTEMS    = 32;
    localparam int COMPONENT_BITS = 64;

    localparam int MASK_W  = 64;
    localparam int WMASK_W = MASK_W + 1;
    localparam int SLOT_W  = 5;
    localparam int LAYER_W = 5;
    localparam int IDX_W   = (MAX_SYSTEMS > 1) ? $clog2(MAX_SYSTEMS) : 1;
    localparam int CNT_W   = $clog2(MAX_SYSTEMS + 1);

    localparam logic [LAYER_W-1:0] LAYER_MAX = {LAYER_W{1'b1}};
    localparam logic [MASK_W-1:0]  COMP_MASK = {MASK_W{1'b1}} >> (MASK_W - COMPONENT_BITS);

    typedef struct packed {
        logic              start_batch;
        logic [MASK_W-1:0] read_mask;
        logic [MASK_W-1:0] write_mask;
        logic              serial;
    } t_in;

    typedef struct packed {
        logic [SLOT_W-1:0]  system_slot;
        logic [LAYER_W-1:0] layer;
        logic               overflow;
    } t_out;

    typedef struct packed {
        logic [MASK_W-1:0]  reads;
        logic [WMASK_W-1:0] writes;
        logic [LAYER_W-1:0] layer;
    } t_entry;

endpackage

[rtl/cls_table.sv]
// System table of the conflict layer scheduler.
// One write port and one read port with registered read data.
// Depends on cls_pkg.
module cls_table import cls_pkg::*; (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_entry           i_wr_data,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_entry           o_rd_data
);

    t_entry r_mem [MAX_SYSTEMS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/conflict_layer_scheduler.sv]
// Conflict layer scheduler: after a transaction is accepted, the stored systems of its batch are
// scanned and the result is then registered at the output; on overflow the scan is skipped.
// Input is taken only in idle, so a new transaction waits until the last result is registered,
// the one table read port visiting a stored system per cycle during the scan; output stalls delay it.
// Synchronous active-low reset empties the table and clears the output register.
// Depends on cls_pkg and cls_table.
module conflict_layer_scheduler import cls_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    t_state             r_state;
    logic [MASK_W-1:0]  r_rd;
    logic [WMASK_W-1:0] r_wr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_idx;
    logic               r_pend;
    logic [LAYER_W-1:0] r_lay;
    logic               r_ovf;
    logic               r_out_valid;
    t_out               r_out;

    logic               in_acc;
    logic [CNT_W-1:0]   start_cnt;
    logic               rd_en;
    logic               out_free;
    logic               tbl_wr;
    t_entry             wr_entry;
    t_entry             rd_entry;
    logic               conflict;
    logic [LAYER_W:0]   cand_wide;
    logic [LAYER_W-1:0] cand;

    assign in_acc    = i_in_valid && (r_state == ST_IDLE);
    assign start_cnt = i_in_data.start_batch ? '0 : r_count;
    assign rd_en     = (r_state == ST_SCAN) && (r_idx < r_count);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign tbl_wr    = (r_state == ST_FIN) && out_free && !r_ovf;

    assign wr_entry.reads  = r_rd;
    assign wr_entry.writes = r_wr;
    assign wr_entry.layer  = r_lay;

    cls_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_wr),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (wr_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (rd_entry)
    );

    // The serial marker sits in the top write bit, so two serial systems collide there.
    assign conflict = (|(rd_entry.writes & ({1'b0, r_rd} | r_wr)))
                   || (|(r_wr & {1'b0, rd_entry.reads}));
    assign cand_wide = {1'b0, rd_entry.layer} + {{LAYER_W{1'b0}}, 1'b1};
    assign cand      = cand_wide[LAYER_W] ? LAYER_MAX : cand_wide[LAYER_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if ((r_state == ST_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_rd    <= i_in_data.read_mask & COMP_MASK;
                        r_wr    <= {i_in_data.serial, i_in_data.write_mask & COMP_MASK};
                        r_count <= start_cnt;
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_lay   <= '0;
                        if (start_cnt >= CNT_W'(MAX_SYSTEMS)) begin
                            r_ovf   <= 1'b1;
                            r_state <= ST_FIN;
                        end else begin
                            r_ovf   <= 1'b0;
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    r_pend <= rd_en;
                    if (rd_en) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    if (r_pend && conflict && (cand > r_lay)) begin
                        r_lay <= cand;
                    end
                    if (!rd_en && !r_pend) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_out.overflow <= r_ovf;
                        if (r_ovf) begin
                            r_out.system_slot <= '0;
                            r_out.layer       <= '0;
                        end else begin
                            r_out.system_slot <= SLOT_W'(r_count);
                            r_out.layer       <= r_lay;
                            r_count           <= r_count + CNT_W'(1);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SYSTEMS))
        else $error("stored system count exceeds capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && out_free && !r_ovf) |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("stored system count did not advance on store");

    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.overflow) |-> (r_out.system_slot == '0 && r_out.layer == '0))
        else $error("overflow result carries nonzero slot or layer");

    a_layer_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && $past(r_state == ST_SCAN)) |-> r_lay >= $past(r_lay))
        else $error("layer decreased during scan");
`endif

endmodule

[tb/conflict_layer_scheduler_tb.sv]
// Self-checking testbench for the conflict layer scheduler.
// Predicts slot, layer and overflow for every accepted system and checks each result in order.
// Depends on cls_pkg and the conflict_layer_scheduler RTL.
module conflict_layer_scheduler_tb;
    import cls_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES   = 6;
    localparam int PHASE_ITEMS    = 460;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    typedef enum int {MASK_NONE, MASK_NEAR, MASK_ANY, MASK_WIDE, MASK_FULL} t_mask_kind;
    typedef enum int {BATCH_SERIAL, BATCH_SPARSE, BATCH_DENSE} t_batch_kind;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_in  in_data = '0;
    logic out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    t_in  pending_systems[$];
    t_out pending_results[$];

    logic [WMASK_W-1:0] sched_reads[MAX_SYSTEMS];
    logic [WMASK_W-1:0] sched_writes[MAX_SYSTEMS];
    int unsigned        sched_layers[MAX_SYSTEMS];
    int unsigned        sched_count = 0;

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    int systems_accepted = 0;
    int results_checked = 0;
    int mismatches = 0;
    int overflow_count = 0;
    int batch_count = 0;
    int deepest_layer = 0;

    conflict_layer_scheduler u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_out schedule_system(input t_in sys);
        t_out               res;
        logic [WMASK_W-1:0] rd;
        logic [WMASK_W-1:0] wr;
        int unsigned        depth;
        res = '0;
        if (sys.start_batch) begin
            sched_count = 0;
        end
        if (sched_count >= MAX_SYSTEMS) begin
            res.overflow = 1'b1;
            overflow_count++;
            return res;
        end
        rd = {1'b0, sys.read_mask & COMP_MASK};
        wr = {sys.serial, sys.write_mask & COMP_MASK};
        depth = 0;
        for (int i = 0; i < sched_count; i++) begin
            if ((|(sched_writes[i] & (rd | wr)) || |(wr & sched_reads[i]))
                    && sched_layers[i] + 1 > depth) begin
                depth = sched_layers[i] + 1;
            end
        end
        if (depth > LAYER_MAX) begin
            depth = LAYER_MAX;
        end
        sched_reads[sched_count]  = rd;
        sched_writes[sched_count] = wr;
        sched_layers[sched_count] = depth;
        res.system_slot = SLOT_W'(sched_count);
        res.layer       = LAYER_W'(depth);
        sched_count++;
        if (depth > deepest_layer) begin
            deepest_layer = depth;
        end
        return res;
    endfunction

    task automatic note_mismatch(input string what, input t_out want, input t_out got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t %s: expected slot %0d layer %0d overflow %0b", $realtime, what,
                     want.system_slot, want.layer, want.overflow);
            $display("    got slot %0d layer %0d overflow %0b",
                     got.system_slot, got.layer, got.overflow);
        end
    endtask

    always @(posedge i_clk) begin : driver
        bit taken;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end else begin
            taken = in_valid && !o_in_stall;
            if (taken) begin
                void'(pending_systems.pop_front());
                pending_results.insert(pending_results.size(), schedule_system(in_data));
                systems_accepted++;
            end
            if (!in_valid || taken) begin
                if (pending_systems.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_systems[0];
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                results_checked++;
                if (pending_results.size() == 0) begin
                    note_mismatch("unexpected result", '0, o_out_data);
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_data.system_slot !== want.system_slot
                            || o_out_data.layer !== want.layer
                            || o_out_data.overflow !== want.overflow) begin
                        note_mismatch("result mismatch", want, o_out_data);
                    end
                end
            end
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL conflict_layer_scheduler");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [MASK_W-1:0] pick_mask(input int kind, input int base);
        logic [MASK_W-1:0] m;
        m = '0;
        case (kind)
            MASK_NEAR: begin
                repeat ($urandom_range(1, 3)) m[base + $urandom_range(0, 7)] = 1'b1;
            end
            MASK_ANY: begin
                m[$urandom_range(0, MASK_W - 1)] = 1'b1;
            end
            MASK_WIDE: begin
                m = {$urandom, $urandom};
            end
            MASK_FULL: begin
                m = '1;
            end
            default: begin
                m = '0;
            end
        endcase
        return m;
    endfunction

    function automatic t_in make_system(input logic start, input t_batch_kind kind,
                                        input int base);
        t_in s;
        s.start_batch = start;
        case (kind)
            BATCH_SERIAL: begin
                s.serial     = 1'b1;
                s.read_mask  = pick_mask($urandom_range(MASK_NONE, MASK_ANY), base);
                s.write_mask = pick_mask($urandom_range(MASK_NONE, MASK_ANY), base);
            end
            BATCH_SPARSE: begin
                s.serial     = ($urandom_range(0, 4) == 0);
                s.read_mask  = pick_mask($urandom_range(MASK_NONE, MASK_ANY), base);
                s.write_mask = pick_mask($urandom_range(MASK_NONE, MASK_ANY), base);
            end
            default: begin
                s.serial     = 1'($urandom_range(0, 1));
                s.read_mask  = pick_mask(($urandom_range(0, 7) == 0) ? MASK_FULL : MASK_WIDE,
                                         base);
                s.write_mask = pick_mask($urandom_range(MASK_NONE, MASK_FULL), base);
            end
        endcase
        return s;
    endfunction

    task automatic queue_batch(input t_batch_kind kind, input int len, input logic fresh);
        int base;
        base = $urandom_range(0, MASK_W - 8);
        batch_count++;
        for (int n = 0; n < len; n++) begin
            pending_systems.insert(pending_systems.size(),
                make_system((n == 0) ? fresh : ($urandom_range(0, 32) == 0), kind, base));
        end
    endtask

    task automatic queue_batches(input int count);
        int queued;
        int len;
        queued = 0;
        while (queued < count) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 20);
            queue_batch(t_batch_kind'($urandom_range(BATCH_SERIAL, BATCH_DENSE)), len,
                        $urandom_range(0, 9) != 0);
            queued += len;
        end
    endtask

    task automatic push_system(input logic start, input logic [MASK_W-1:0] rd,
                               input logic [MASK_W-1:0] wr, input logic ser);
        t_in s;
        s.start_batch = start;
        s.read_mask   = rd;
        s.write_mask  = wr;
        s.serial      = ser;
        pending_systems.insert(pending_systems.size(), s);
    endtask

    task automatic wait_drained();
        while (pending_systems.size() != 0 || in_valid || pending_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input bit hold_receiver,
                             input bit pause_sender);
        idle_pct  = idle;
        stall_pct = stall;
        queue_batches(PHASE_ITEMS / 2);
        if (hold_receiver) begin
            hold_requests++;
        end
        if (pause_sender) begin
            wait_drained();
            repeat (20) @(negedge i_clk);
        end
        queue_batches(PHASE_ITEMS / 2);
        wait_drained();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_system(1'b1, '0, '0, 1'b0);
        push_system(1'b0, '1, '0, 1'b0);
        push_system(1'b0, '0, '1, 1'b0);
        push_system(1'b0, '0, '0, 1'b1);
        push_system(1'b0, '0, '0, 1'b1);
        push_system(1'b0, 64'h8000_0000_0000_0000, '0, 1'b0);
        push_system(1'b0, '0, 64'h1, 1'b1);
        push_system(1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0);
        push_system(1'b0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        push_system(1'b0, '1, '1, 1'b1);
        push_system(1'b1, '1, '1, 1'b1);
        push_system(1'b1, '0, 64'h8000_0000_0000_0000, 1'b0);
        push_system(1'b0, 64'h8000_0000_0000_0000, '0, 1'b0);
        wait_drained();

        // A serial chain longer than the table reaches the top layer and then overflows;
        // the next batch restarts on an empty table.
        queue_batch(BATCH_SERIAL, MAX_SYSTEMS + 2, 1'b1);
        queue_batch(BATCH_SPARSE, 3, 1'b1);
        wait_drained();

        run_phase(0, 0, 1'b1, 1'b0);
        run_phase(84, 0, 1'b0, 1'b0);
        run_phase(0, 84, 1'b0, 1'b0);
        run_phase(31, 31, 1'b0, 1'b1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0d results never arrived", pending_results.size());
            mismatches += pending_results.size();
        end

        $display("Scheduled %0d systems in %0d batches, %0d overflowed, deepest layer %0d.",
                 systems_accepted, batch_count, overflow_count, deepest_layer);
        $display("Checked %0d results, %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("PASS conflict_layer_scheduler");
        end else begin
            $display("FAIL conflict_layer_scheduler");
        end
        $finish;
    end

endmodule
